[sv/ledcfd_pkg.sv]
package ledcfd_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int EMA_DIVISOR   = 16;
  localparam int EMA_SHIFT     = $clog2(EMA_DIVISOR);
  localparam int AVG_COUNT_MAX = 255;
  localparam int MASK_W        = 4;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int AVG_W         = 24;
  localparam int FRAC_W        = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LOW_THRESH   = 3'd0,
    CFG_MIN_SAMPLES  = 3'd1,
    CFG_LOW_LIMIT    = 3'd2,
    CFG_FAIL_LIMIT   = 3'd3,
    CFG_INTERVAL     = 3'd4,
    CFG_AVG_TIMEOUT  = 3'd5,
    CFG_EMA_MULT     = 3'd6,
    CFG_STARTUP_LIM  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        command;
    logic [1:0]  channel;
    logic [15:0] voltage_mv;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [15:0]       average_mv;
    logic [15:0]       minimum_mv;
    logic [15:0]       maximum_mv;
    logic [MASK_W-1:0] failed_mask;
    logic [MASK_W-1:0] healthy_mask;
    logic              window_judged;
  } out_item_t;

  typedef struct packed {
    logic [15:0] low_voltage_threshold;
    logic [15:0] min_window_samples;
    logic [15:0] low_sample_limit;
    logic [7:0]  fail_count_limit;
    logic [15:0] check_interval_s;
    logic [15:0] average_timeout_s;
    logic [15:0] ema_multiplier;
    logic [7:0]  startup_sample_limit;
  } cfg_t;

  typedef struct packed {
    logic        sample;
    logic        tick;
    logic        judge;
    logic [15:0] voltage_mv;
    logic [31:0] now_seconds;
  } chan_op_t;

  typedef struct packed {
    logic [15:0] average_mv;
    logic [15:0] minimum_mv;
    logic [15:0] maximum_mv;
    logic        failed;
  } chan_stat_t;

endpackage

[sv/ledcfd_cfg.sv]
module ledcfd_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ledcfd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ledcfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output ledcfd_pkg::cfg_t                   cfg
);
  import ledcfd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_e'(cfg_addr))
        CFG_LOW_THRESH:  cfg_nxt.low_voltage_threshold = cfg_wdata;
        CFG_MIN_SAMPLES: cfg_nxt.min_window_samples    = cfg_wdata;
        CFG_LOW_LIMIT:   cfg_nxt.low_sample_limit      = cfg_wdata;
        CFG_FAIL_LIMIT:  cfg_nxt.fail_count_limit      = cfg_wdata[7:0];
        CFG_INTERVAL:    cfg_nxt.check_interval_s      = cfg_wdata;
        CFG_AVG_TIMEOUT: cfg_nxt.average_timeout_s     = cfg_wdata;
        CFG_EMA_MULT:    cfg_nxt.ema_multiplier        = cfg_wdata;
        CFG_STARTUP_LIM: cfg_nxt.startup_sample_limit  = cfg_wdata[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_voltage_threshold <= 16'd500;
      cfg_r.min_window_samples    <= 16'd100;
      cfg_r.low_sample_limit      <= 16'd100;
      cfg_r.fail_count_limit      <= 8'd3;
      cfg_r.check_interval_s      <= 16'd10;
      cfg_r.average_timeout_s     <= 16'd60;
      cfg_r.ema_multiplier        <= 16'd1;
      cfg_r.startup_sample_limit  <= 8'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[sv/ledcfd_chan.sv]
module ledcfd_chan (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  ledcfd_pkg::cfg_t       cfg,
  input  ledcfd_pkg::chan_op_t   op,
  output ledcfd_pkg::chan_stat_t stat
);
  import ledcfd_pkg::*;

  logic [AVG_W-1:0] avg_r,     avg_nxt;
  logic [15:0]      min_r,     min_nxt;
  logic [15:0]      max_r,     max_nxt;
  logic [7:0]       avg_cnt_r, avg_cnt_nxt;
  logic [31:0]      last_r,    last_nxt;
  logic [15:0]      low_r,     low_nxt;
  logic [15:0]      win_r,     win_nxt;
  logic [7:0]       fail_r,    fail_nxt;

  logic signed [AVG_W+1:0]  diff;
  logic signed [AVG_W+1:0]  half;
  logic signed [AVG_W+18:0] prod;
  logic signed [AVG_W+19:0] rnd;
  logic signed [AVG_W+19:0] scaled;
  logic signed [AVG_W+19:0] step;
  logic signed [AVG_W+19:0] sum;
  logic                     stale;

  // d = v*256 - avg, step truncated toward zero
  always_comb begin
    diff   = $signed({2'b00, op.voltage_mv, {FRAC_W{1'b0}}}) - $signed({2'b00, avg_r});
    half   = (diff + $signed({{(AVG_W+1){1'b0}}, diff[AVG_W+1]})) >>> 1;
    prod   = diff * $signed({1'b0, cfg.ema_multiplier});
    rnd    = prod[AVG_W+18] ? (AVG_W+20)'(EMA_DIVISOR - 1) : '0;
    scaled = ($signed({prod[AVG_W+18], prod}) + rnd) >>> EMA_SHIFT;
    step   = (avg_cnt_r < cfg.startup_sample_limit) ?
             $signed({{18{half[AVG_W+1]}}, half}) : scaled;
    sum    = $signed({20'd0, avg_r}) + step;
  end

  assign stale = {1'b0, op.now_seconds} > ({1'b0, last_r} + {17'd0, cfg.average_timeout_s});

  always_comb begin
    avg_nxt     = avg_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    avg_cnt_nxt = avg_cnt_r;
    last_nxt    = last_r;
    low_nxt     = low_r;
    win_nxt     = win_r;
    fail_nxt    = fail_r;
    if (op.sample) begin
      if (op.voltage_mv < cfg.low_voltage_threshold && low_r != 16'hFFFF) begin
        low_nxt = low_r + 16'd1;
      end
      if (win_r != 16'hFFFF) begin
        win_nxt = win_r + 16'd1;
      end
      if (op.voltage_mv > max_r) begin
        max_nxt = op.voltage_mv;
      end
      if (op.voltage_mv < min_r) begin
        min_nxt = op.voltage_mv;
      end
      if (sum[AVG_W+19]) begin
        avg_nxt = '0;
      end else if (|sum[AVG_W+18:AVG_W]) begin
        avg_nxt = '1;
      end else begin
        avg_nxt = sum[AVG_W-1:0];
      end
      if (32'(avg_cnt_r) < AVG_COUNT_MAX) begin
        avg_cnt_nxt = avg_cnt_r + 8'd1;
      end
      last_nxt = op.now_seconds;
    end else if (op.tick) begin
      if (stale) begin
        avg_cnt_nxt = '0;
      end
      if (op.judge) begin
        if (win_r > cfg.min_window_samples) begin
          if (low_r > cfg.low_sample_limit) begin
            if (fail_r < cfg.fail_count_limit) begin
              fail_nxt = fail_r + 8'd1;
            end
          end else begin
            fail_nxt = '0;
          end
        end
        low_nxt = '0;
        win_nxt = '0;
        min_nxt = 16'hFFFF;
        max_nxt = '0;
      end
    end
  end

  assign stat.average_mv = avg_nxt[AVG_W-1:FRAC_W];
  assign stat.minimum_mv = min_nxt;
  assign stat.maximum_mv = max_nxt;
  assign stat.failed     = fail_nxt >= cfg.fail_count_limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r     <= '0;
      min_r     <= 16'hFFFF;
      max_r     <= '0;
      avg_cnt_r <= '0;
      last_r    <= '0;
      low_r     <= '0;
      win_r     <= '0;
      fail_r    <= '0;
    end else if (en) begin
      avg_r     <= avg_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      avg_cnt_r <= avg_cnt_nxt;
      last_r    <= last_nxt;
      low_r     <= low_nxt;
      win_r     <= win_nxt;
      fail_r    <= fail_nxt;
    end
  end

endmodule

[sv/led_channel_fail_detector.sv]
// LED channel fail detector. Takes one word per clock while the output is not
// stalled: a voltage sample for one channel or a periodic tick, and returns
// exactly one result word for each. A word is registered on input and its
// whole effect (counters, min/max, the running average, stale checks and the
// once-per-interval window judgement) is computed from that register into the
// result register. The compute step is bounded by the average update: subtract,
// a 26 x 17 bit multiply, add and clamp. There is no clearing pass; all state
// but the input and result data words is reset. The config port always
// accepts writes and should be used only while idle.
module led_channel_fail_detector #(
  parameter int CHANNELS = ledcfd_pkg::CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ledcfd_pkg::in_item_t               in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ledcfd_pkg::out_item_t              out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ledcfd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ledcfd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ledcfd_pkg::*;

  localparam int SEL_W   = $clog2(CHANNELS) + 2;
  localparam int MASK_CH = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

  cfg_t        cfg;
  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_data_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic        advance;
  logic        judge_now;
  logic [31:0] last_judge_r, last_judge_nxt;
  logic [MASK_W-1:0] failed_r, failed_nxt;
  logic [MASK_W-1:0] healthy_r, healthy_nxt;
  logic [CHANNELS-1:0] fail_vec;
  chan_stat_t  stats [CHANNELS];
  chan_op_t    ops [CHANNELS];

  ledcfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // advance the held word into the result register when that slot frees up
  assign advance      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready     = !s1_valid_r || advance;
  assign s1_valid_nxt = in_ready ? in_valid : s1_valid_r;
  assign judge_now    = s1_data_r.command &&
                        ({1'b0, s1_data_r.now_seconds} >
                         ({1'b0, last_judge_r} + {17'd0, cfg.check_interval_s}));

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    assign ops[c].sample      = !s1_data_r.command &&
                                (SEL_W'(s1_data_r.channel) == SEL_W'(c));
    assign ops[c].tick        = s1_data_r.command;
    assign ops[c].judge       = judge_now;
    assign ops[c].voltage_mv  = s1_data_r.voltage_mv;
    assign ops[c].now_seconds = s1_data_r.now_seconds;
    assign fail_vec[c]        = stats[c].failed;

    ledcfd_chan u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (advance),
      .cfg   (cfg),
      .op    (ops[c]),
      .stat  (stats[c])
    );
  end

  always_comb begin
    failed_nxt     = failed_r;
    healthy_nxt    = healthy_r;
    last_judge_nxt = last_judge_r;
    if (judge_now) begin
      last_judge_nxt = s1_data_r.now_seconds;
      failed_nxt     = '0;
      healthy_nxt    = '0;
      for (int c = 0; c < MASK_CH; c++) begin
        failed_nxt[c]  = fail_vec[c];
        healthy_nxt[c] = !fail_vec[c];
      end
    end
  end

  always_comb begin
    out_data_nxt               = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (SEL_W'(s1_data_r.channel) == SEL_W'(c)) begin
        out_data_nxt.average_mv = stats[c].average_mv;
        out_data_nxt.minimum_mv = stats[c].minimum_mv;
        out_data_nxt.maximum_mv = stats[c].maximum_mv;
      end
    end
    out_data_nxt.failed_mask   = failed_nxt;
    out_data_nxt.healthy_mask  = healthy_nxt;
    out_data_nxt.window_judged = judge_now;
  end

  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      last_judge_r <= '0;
      failed_r     <= '0;
      healthy_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        last_judge_r <= last_judge_nxt;
        failed_r     <= failed_nxt;
        healthy_r    <= healthy_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_masks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.failed_mask & out_data_r.healthy_mask) == '0)
    else $error("failed and healthy masks overlap");

  a_judge_time: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && judge_now) |=> last_judge_r == $past(s1_data_r.now_seconds))
    else $error("judgement time not recorded");

  a_judged_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !s1_data_r.command) |=> !out_data_r.window_judged)
    else $error("sample reported a judgement");

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> s1_valid_r && $stable(s1_data_r))
    else $error("held word lost under back-pressure");

endmodule
